// ===== design/bpm_pkg.sv =====
// bpm_pkg: shared widths, register indexes and reset values for the
// battery power monitor. No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package bpm_pkg;

    // Field widths
    localparam int TimeW  = 32;
    localparam int VoltW  = 16;
    localparam int ModeW  = 2;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    // Stream payload widths (packed, padded to whole bytes)
    localparam int InDataW  = 80;
    localparam int OutDataW = 40;

    // Output payload bit positions
    localparam int OutPowerBit   = 0;
    localparam int OutChangedBit = 1;
    localparam int OutCanFlyBit  = 2;
    localparam int OutShutBit    = 3;
    localparam int OutMinLsb     = 4;
    localparam int OutMaxLsb     = 20;
    localparam int OutEn1Bit     = 36;
    localparam int OutEn2Bit     = 37;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_LOW_VOLTAGE   = 3'd0,
        CFG_CRIT_VOLTAGE  = 3'd1,
        CFG_LOW_TIMEOUT   = 3'd2,
        CFG_CRIT_TIMEOUT  = 3'd3,
        CFG_IDLE_TIMEOUT  = 3'd4,
        CFG_CHARGE_MODE   = 3'd5
    } cfg_index_t;

    // Charge modes
    typedef enum logic [ModeW-1:0] {
        CHARGE_100MA = 2'd0,
        CHARGE_500MA = 2'd1,
        CHARGE_MAX   = 2'd2,
        CHARGE_NONE  = 2'd3
    } charge_mode_t;

    // Power states
    localparam logic PWR_BATTERY = 1'b0;
    localparam logic PWR_LOW     = 1'b1;

    // Reset values
    localparam logic [VoltW-1:0] LowVoltageReset  = 16'd6400;
    localparam logic [VoltW-1:0] CritVoltageReset = 16'd6000;
    localparam logic [TimeW-1:0] LowTimeoutReset  = 32'd5000;
    localparam logic [TimeW-1:0] CritTimeoutReset = 32'd5000;
    localparam logic [TimeW-1:0] IdleTimeoutReset = 32'd300000;
    localparam logic [VoltW-1:0] MinVoltReset     = 16'd6000;
    localparam logic [VoltW-1:0] MaxVoltReset     = 16'd0;

endpackage

// ===== design/battery_power_monitor.sv =====
// battery_power_monitor: battery under-voltage monitor with low/critical
// timeouts, shutdown request, voltage min/max and charger enables. Uses bpm_pkg.
`timescale 1ns / 1ps
//
//  Channel    Direction  Handshake              Payload
//  s_         in         s_tvalid / s_tready    now_ms, voltage_mv, inactivity_ms
//  m_         out        m_tvalid / m_tready    status flags, min/max voltage, charge pins
//  cfg_       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One sample per clock sustained while m_tready holds; a result passes through
//  the input register, then the result register, before it leaves.
//  Stalls on m_ back up through the result register into the input register;
//  s_tready drops only when both hold data and m_tready is low.
//  aresetn (synchronous, active low) restores register defaults, time stamps,
//  state and min/max trackers, and empties both stages.
//  cfg_ready is always high; writes to unused indexes are dropped.

module battery_power_monitor (
    input  logic                          aclk,
    input  logic                          aresetn,
    // {inactivity_ms[79:48], voltage_mv[47:32], now_ms[31:0]}
    input  logic [bpm_pkg::InDataW-1:0]   s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // {pad[39:38], charge_en2[37], charge_en1[36], voltage_max_mv[35:20],
    //  voltage_min_mv[19:4], shutdown_request[3], can_fly[2],
    //  state_changed[1], power_state[0]}
    output logic [bpm_pkg::OutDataW-1:0]  m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpm_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bpm_pkg::CfgDataW-1:0]  cfg_data
);

    // Configuration registers
    logic [bpm_pkg::VoltW-1:0] low_voltage_reg;
    logic [bpm_pkg::VoltW-1:0] crit_voltage_reg;
    logic [bpm_pkg::TimeW-1:0] low_timeout_reg;
    logic [bpm_pkg::TimeW-1:0] crit_timeout_reg;
    logic [bpm_pkg::TimeW-1:0] idle_timeout_reg;
    logic [bpm_pkg::ModeW-1:0] charge_mode_reg;

    // Input stage
    logic                      in_valid_reg;
    logic [bpm_pkg::TimeW-1:0] now_reg;
    logic [bpm_pkg::VoltW-1:0] volt_reg;
    logic [bpm_pkg::TimeW-1:0] idle_reg;

    // Monitor state
    logic [bpm_pkg::TimeW-1:0] low_stamp_reg,  low_stamp_next;
    logic [bpm_pkg::TimeW-1:0] crit_stamp_reg, crit_stamp_next;
    logic                      prev_state_reg;
    logic                      can_fly_reg,    can_fly_next;
    logic [bpm_pkg::VoltW-1:0] min_volt_reg,   min_volt_next;
    logic [bpm_pkg::VoltW-1:0] max_volt_reg,   max_volt_next;

    // Result stage
    logic                         out_valid_reg;
    logic [bpm_pkg::OutDataW-1:0] out_data_reg, out_data_next;

    logic advance;
    logic state_now;
    logic changed;
    logic shutdown;
    logic [bpm_pkg::TimeW-1:0] low_elapsed;
    logic [bpm_pkg::TimeW-1:0] crit_elapsed;

    // Handshake: move the input stage forward when the result slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_voltage_reg  <= bpm_pkg::LowVoltageReset;
            crit_voltage_reg <= bpm_pkg::CritVoltageReset;
            low_timeout_reg  <= bpm_pkg::LowTimeoutReset;
            crit_timeout_reg <= bpm_pkg::CritTimeoutReset;
            idle_timeout_reg <= bpm_pkg::IdleTimeoutReset;
            charge_mode_reg  <= bpm_pkg::CHARGE_500MA;
        end else if (cfg_valid) begin
            case (bpm_pkg::cfg_index_t'(cfg_index))
                bpm_pkg::CFG_LOW_VOLTAGE:  low_voltage_reg  <= cfg_data[bpm_pkg::VoltW-1:0];
                bpm_pkg::CFG_CRIT_VOLTAGE: crit_voltage_reg <= cfg_data[bpm_pkg::VoltW-1:0];
                bpm_pkg::CFG_LOW_TIMEOUT:  low_timeout_reg  <= cfg_data[bpm_pkg::TimeW-1:0];
                bpm_pkg::CFG_CRIT_TIMEOUT: crit_timeout_reg <= cfg_data[bpm_pkg::TimeW-1:0];
                bpm_pkg::CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data[bpm_pkg::TimeW-1:0];
                bpm_pkg::CFG_CHARGE_MODE:  charge_mode_reg  <= cfg_data[bpm_pkg::ModeW-1:0];
                default: ;
            endcase
        end
    end

    // Capture the sample on an input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            now_reg  <= s_tdata[31:0];
            volt_reg <= s_tdata[47:32];
            idle_reg <= s_tdata[79:48];
        end
    end

    // Evaluate one sample against the stored stamps and thresholds
    always_comb begin
        max_volt_next   = (volt_reg > max_volt_reg) ? volt_reg : max_volt_reg;
        min_volt_next   = (volt_reg < min_volt_reg) ? volt_reg : min_volt_reg;
        low_stamp_next  = (volt_reg > low_voltage_reg)  ? now_reg : low_stamp_reg;
        crit_stamp_next = (volt_reg > crit_voltage_reg) ? now_reg : crit_stamp_reg;

        // Elapsed times wrap modulo 2^32
        low_elapsed  = now_reg - low_stamp_next;
        crit_elapsed = now_reg - crit_stamp_next;

        state_now = (low_elapsed > low_timeout_reg) ? bpm_pkg::PWR_LOW
                                                    : bpm_pkg::PWR_BATTERY;
        changed   = (state_now != prev_state_reg);
        can_fly_next = changed ? (state_now == bpm_pkg::PWR_BATTERY) : can_fly_reg;

        if (state_now == bpm_pkg::PWR_LOW) begin
            shutdown = (crit_elapsed > crit_timeout_reg);
        end else begin
            shutdown = (idle_reg > idle_timeout_reg);
        end

        out_data_next = '0;
        out_data_next[bpm_pkg::OutPowerBit]   = state_now;
        out_data_next[bpm_pkg::OutChangedBit] = changed;
        out_data_next[bpm_pkg::OutCanFlyBit]  = can_fly_next;
        out_data_next[bpm_pkg::OutShutBit]    = shutdown;
        out_data_next[bpm_pkg::OutMinLsb +: bpm_pkg::VoltW] = min_volt_next;
        out_data_next[bpm_pkg::OutMaxLsb +: bpm_pkg::VoltW] = max_volt_next;
        out_data_next[bpm_pkg::OutEn1Bit] =
            (bpm_pkg::charge_mode_t'(charge_mode_reg) == bpm_pkg::CHARGE_500MA);
        out_data_next[bpm_pkg::OutEn2Bit] =
            (bpm_pkg::charge_mode_t'(charge_mode_reg) == bpm_pkg::CHARGE_MAX);
    end

    // Commit state when the sample moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_stamp_reg  <= '0;
            crit_stamp_reg <= '0;
            prev_state_reg <= bpm_pkg::PWR_LOW;
            can_fly_reg    <= 1'b0;
            min_volt_reg   <= bpm_pkg::MinVoltReset;
            max_volt_reg   <= bpm_pkg::MaxVoltReset;
        end else if (advance) begin
            low_stamp_reg  <= low_stamp_next;
            crit_stamp_reg <= crit_stamp_next;
            prev_state_reg <= state_now;
            can_fly_reg    <= can_fly_next;
            min_volt_reg   <= min_volt_next;
            max_volt_reg   <= max_volt_next;
        end
    end

    // Result register: load on advance, drop after the output transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== design/bpm_checker.sv =====
// bpm_checker: port-level assertions for battery_power_monitor, bound to the
// top level below. Uses bpm_pkg for payload bit positions.
`timescale 1ns / 1ps

module bpm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic [bpm_pkg::OutDataW-1:0]  m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    // Stalled result holds until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A state change sets can_fly opposite to the new state
    a_can_fly: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[bpm_pkg::OutChangedBit] |->
            (m_tdata[bpm_pkg::OutCanFlyBit] != m_tdata[bpm_pkg::OutPowerBit]))
        else $error("can_fly does not follow state change");

    // The reported min voltage never lies above the reported max
    a_min_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[bpm_pkg::OutMinLsb +: bpm_pkg::VoltW] <=
                      m_tdata[bpm_pkg::OutMaxLsb +: bpm_pkg::VoltW]))
        else $error("voltage min above max");

    // Charger pins are never both enabled
    a_charge_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[bpm_pkg::OutEn1Bit] && m_tdata[bpm_pkg::OutEn2Bit]))
        else $error("both charge enables high");

    // With the result slot free, the input side cannot be blocked
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind battery_power_monitor bpm_checker u_bpm_checker (.*);
